// ===== rtl/qapm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared constants, register codes and control types for the quad attitude
// PID controller and X-pattern motor mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF   = 32;

  localparam int GAIN_W  = 24;
  localparam int FRAC_W  = 16;
  localparam int MOTOR_W = 13;
  localparam logic [MOTOR_W-1:0] MOTOR_MAX = 13'd4096;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KP_ROLL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_PITCH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_YAW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_THRUST = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_ROLL   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_PITCH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_YAW    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KI_AXES   = 4'd7;

  localparam logic [GAIN_W-1:0] RST_KP_ROLL   = 24'd655;
  localparam logic [GAIN_W-1:0] RST_KP_PITCH  = 24'd655;
  localparam logic [GAIN_W-1:0] RST_KP_YAW    = 24'd32768;
  localparam logic [GAIN_W-1:0] RST_KP_THRUST = 24'd52429;
  localparam logic [GAIN_W-1:0] RST_KD_ROLL   = 24'd13107;
  localparam logic [GAIN_W-1:0] RST_KD_PITCH  = 24'd13107;
  localparam logic [GAIN_W-1:0] RST_KD_YAW    = 24'd13107;
  localparam logic [GAIN_W-1:0] RST_KI_AXES   = 24'd0;

  // lane pipeline depth, the mixer output register follows
  localparam int NSTG = 5;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic            upd;
  } stage_ctl_t;

  // width of one lane's control output
  function automatic int u_width(input int aw, input int sw);
    int mx;
    begin
      mx = (sw > aw + 2) ? sw : aw + 2;
      return GAIN_W + mx + 4;
    end
  endfunction

endpackage

// ===== rtl/qapm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_if
// Valid/ready channels: control tick request in, motor command request out.
// ----------------------------------------------------------------------------
interface qapm_in_if #(
  parameter int AW = qapm_pkg::ANGLE_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] want_thrust;
  logic signed [AW-1:0] want_roll;
  logic signed [AW-1:0] want_pitch;
  logic signed [AW-1:0] want_yaw;
  logic signed [AW-1:0] meas_roll;
  logic signed [AW-1:0] meas_pitch;
  logic signed [AW-1:0] meas_yaw;

  modport source (
    output valid, want_thrust, want_roll, want_pitch, want_yaw,
    output meas_roll, meas_pitch, meas_yaw,
    input  ready
  );
  modport sink (
    input  valid, want_thrust, want_roll, want_pitch, want_yaw,
    input  meas_roll, meas_pitch, meas_yaw,
    output ready
  );
endinterface

interface qapm_out_if ();
  logic                           valid;
  logic                           ready;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_front_left;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_back_left;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_back_right;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_front_right;

  modport source (
    output valid, motor_front_left, motor_back_left,
    output motor_back_right, motor_front_right,
    input  ready
  );
  modport sink (
    input  valid, motor_front_left, motor_back_left,
    input  motor_back_right, motor_front_right,
    output ready
  );
endinterface

// ===== rtl/qapm_axis_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_axis_lane
// One attitude axis: error, saturating error sum, previous error, and the
// P + I + D products brought back to Q.12, over five pipeline stages.
// ----------------------------------------------------------------------------
module qapm_axis_lane #(
  parameter int AW = qapm_pkg::ANGLE_WIDTH_DEF,
  parameter int SW = qapm_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qapm_pkg::stage_ctl_t               ctl,
  input  logic signed [AW-1:0]               want,
  input  logic signed [AW-1:0]               meas,
  input  logic [qapm_pkg::GAIN_W-1:0]        kp,
  input  logic [qapm_pkg::GAIN_W-1:0]        kd,
  input  logic [qapm_pkg::GAIN_W-1:0]        ki,
  output logic signed [qapm_pkg::u_width(AW, SW)-1:0] u
);

  localparam int GW   = qapm_pkg::GAIN_W;
  localparam int FR   = qapm_pkg::FRAC_W;
  localparam int UW   = qapm_pkg::u_width(AW, SW);
  localparam int EW   = AW + 1;
  localparam int DW   = AW + 2;
  localparam int TW   = ((SW > EW) ? SW : EW) + 1;
  localparam int LO   = SW / 2;
  localparam int HW   = SW - LO;
  localparam int PEW  = GW + 1 + EW;
  localparam int PDW  = GW + 1 + DW;
  localparam int PHW  = GW + 1 + HW;
  localparam int PLW  = GW + LO;
  localparam int PIW  = GW + SW + 2;

  localparam logic signed [TW-1:0] SMAX = {{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [TW-1:0] SMIN = ~SMAX;

  // error sum and previous error
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic signed [EW-1:0]  last_r;

  logic signed [EW-1:0]  e0_r, e0_nxt;
  logic signed [EW-1:0]  e1_r;
  logic signed [DW-1:0]  d1_r, d1_nxt;
  logic signed [SW-1:0]  s1_r;
  logic signed [PEW-1:0] pe_r, pe_nxt;
  logic signed [PDW-1:0] pd_r, pd_nxt;
  logic signed [PHW-1:0] phi_r, phi_nxt;
  logic [PLW-1:0]        plo_r, plo_nxt;
  logic signed [UW-1:0]  tp_r, tp_nxt;
  logic signed [UW-1:0]  td_r, td_nxt;
  logic signed [UW-1:0]  ti_r, ti_nxt;
  logic signed [UW-1:0]  u_r, u_nxt;

  logic signed [TW-1:0]  acc;
  logic signed [HW-1:0]  s_hi;
  logic [LO-1:0]         s_lo;
  logic signed [PIW-1:0] pi_sum;
  logic signed [UW-1:0]  pe_x, pd_x, pi_x;

  always_comb begin
    e0_nxt = {want[AW-1], want} - {meas[AW-1], meas};

    acc = {{(TW-SW){sum_r[SW-1]}}, sum_r} + {{(TW-EW){e0_r[EW-1]}}, e0_r};
    if (acc > SMAX) begin
      sum_nxt = SMAX[SW-1:0];
    end else if (acc < SMIN) begin
      sum_nxt = SMIN[SW-1:0];
    end else begin
      sum_nxt = acc[SW-1:0];
    end
    d1_nxt = {e0_r[EW-1], e0_r} - {last_r[EW-1], last_r};

    // integral product split in two halves of the sum
    s_hi    = s1_r[SW-1:LO];
    s_lo    = s1_r[LO-1:0];
    pe_nxt  = $signed({1'b0, kp}) * e1_r;
    pd_nxt  = $signed({1'b0, kd}) * d1_r;
    phi_nxt = $signed({1'b0, ki}) * s_hi;
    plo_nxt = ki * s_lo;

    pi_sum = $signed({{(PIW-LO-PHW){phi_r[PHW-1]}}, phi_r, {LO{1'b0}}})
           + $signed({{(PIW-PLW){1'b0}}, plo_r});
    pe_x   = {{(UW-PEW){pe_r[PEW-1]}}, pe_r};
    pd_x   = {{(UW-PDW){pd_r[PDW-1]}}, pd_r};
    pi_x   = {{(UW-PIW){pi_sum[PIW-1]}}, pi_sum};
    tp_nxt = pe_x >>> FR;
    td_nxt = pd_x >>> FR;
    ti_nxt = pi_x >>> FR;

    u_nxt = tp_r + td_r + ti_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else if (ctl.upd) begin
      sum_r  <= sum_nxt;
      last_r <= e0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      e0_r <= e0_nxt;
    end
    if (ctl.en[1]) begin
      e1_r <= e0_r;
      d1_r <= d1_nxt;
      s1_r <= sum_nxt;
    end
    if (ctl.en[2]) begin
      pe_r  <= pe_nxt;
      pd_r  <= pd_nxt;
      phi_r <= phi_nxt;
      plo_r <= plo_nxt;
    end
    if (ctl.en[3]) begin
      tp_r <= tp_nxt;
      td_r <= td_nxt;
      ti_r <= ti_nxt;
    end
    if (ctl.en[4]) begin
      u_r <= u_nxt;
    end
  end

  assign u = u_r;

endmodule

// ===== rtl/qapm_thrust_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_thrust_lane
// Proportional thrust term, floor-scaled to Q.12 and timed to match the
// attitude lanes.
// ----------------------------------------------------------------------------
module qapm_thrust_lane #(
  parameter int AW = qapm_pkg::ANGLE_WIDTH_DEF,
  parameter int SW = qapm_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  qapm_pkg::stage_ctl_t               ctl,
  input  logic signed [AW-1:0]               want,
  input  logic [qapm_pkg::GAIN_W-1:0]        kp,
  output logic signed [qapm_pkg::u_width(AW, SW)-1:0] t
);

  localparam int GW  = qapm_pkg::GAIN_W;
  localparam int FR  = qapm_pkg::FRAC_W;
  localparam int UW  = qapm_pkg::u_width(AW, SW);
  localparam int PTW = GW + 1 + AW;

  logic signed [AW-1:0]  w0_r;
  logic signed [PTW-1:0] p1_r, p1_nxt;
  logic signed [UW-1:0]  p1_x;
  logic signed [UW-1:0]  t2_r, t2_nxt;
  logic signed [UW-1:0]  t3_r;
  logic signed [UW-1:0]  t4_r;

  always_comb begin
    p1_nxt = $signed({1'b0, kp}) * w0_r;
    p1_x   = {{(UW-PTW){p1_r[PTW-1]}}, p1_r};
    t2_nxt = p1_x >>> FR;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      w0_r <= want;
    end
    if (ctl.en[1]) begin
      p1_r <= p1_nxt;
    end
    if (ctl.en[2]) begin
      t2_r <= t2_nxt;
    end
    if (ctl.en[3]) begin
      t3_r <= t2_r;
    end
    if (ctl.en[4]) begin
      t4_r <= t3_r;
    end
  end

  assign t = t4_r;

endmodule

// ===== rtl/qapm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_mixer
// X-pattern mix of thrust, roll, pitch and yaw into four motor commands,
// clamped to 0..4096, held in the output register.
// ----------------------------------------------------------------------------
module qapm_mixer #(
  parameter int UW = qapm_pkg::u_width(qapm_pkg::ANGLE_WIDTH_DEF, qapm_pkg::SUM_WIDTH_DEF)
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [UW-1:0]          t,
  input  logic signed [UW-1:0]          r,
  input  logic signed [UW-1:0]          p,
  input  logic signed [UW-1:0]          y,
  output logic [qapm_pkg::MOTOR_W-1:0]  m_fl,
  output logic [qapm_pkg::MOTOR_W-1:0]  m_bl,
  output logic [qapm_pkg::MOTOR_W-1:0]  m_br,
  output logic [qapm_pkg::MOTOR_W-1:0]  m_fr
);

  localparam int MW = UW + 2;
  localparam int OW = qapm_pkg::MOTOR_W;
  localparam logic signed [MW-1:0] MAX_X = {{(MW-OW){1'b0}}, qapm_pkg::MOTOR_MAX};

  logic signed [MW-1:0] tx, rx, px, yx;
  logic signed [MW-1:0] s_fl, s_bl, s_br, s_fr;
  logic [OW-1:0] fl_r, bl_r, br_r, fr_r;
  logic [OW-1:0] fl_nxt, bl_nxt, br_nxt, fr_nxt;

  function automatic logic [OW-1:0] clamp(input logic signed [MW-1:0] v);
    logic [OW-1:0] res;
    begin
      if (v[MW-1]) begin
        res = '0;
      end else if (v > MAX_X) begin
        res = qapm_pkg::MOTOR_MAX;
      end else begin
        res = v[OW-1:0];
      end
      return res;
    end
  endfunction

  always_comb begin
    tx = {{2{t[UW-1]}}, t};
    rx = {{2{r[UW-1]}}, r};
    px = {{2{p[UW-1]}}, p};
    yx = {{2{y[UW-1]}}, y};
    s_fl = tx - px + rx + yx;
    s_bl = tx + px + rx - yx;
    s_br = tx + px - rx + yx;
    s_fr = tx - px - rx - yx;
    fl_nxt = clamp(s_fl);
    bl_nxt = clamp(s_bl);
    br_nxt = clamp(s_br);
    fr_nxt = clamp(s_fr);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fl_r <= fl_nxt;
      bl_r <= bl_nxt;
      br_r <= br_nxt;
      fr_r <= fr_nxt;
    end
  end

  assign m_fl = fl_r;
  assign m_bl = bl_r;
  assign m_br = br_r;
  assign m_fr = fr_r;

endmodule

// ===== rtl/quad_attitude_pid_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer_top
// Quadrotor attitude PID controller with X-pattern motor mixer.
// ----------------------------------------------------------------------------
// One control tick per request: roll, pitch and yaw each run P + I + D in a
// lane of their own, thrust runs P in a fourth lane, and a mixer stage turns
// the four terms into motor commands clamped to 0..4096 (4096 means 1.0).
// A new tick is taken every cycle unless the full lanes wait on out_ch.ready.
// The first of the five lane stages (error, error-sum update, gain multiply,
// Q.12 scaling, term sum) loads at the accepting edge, and the mixer output
// register follows the last one. The error sum and previous error advance in
// lane stage two, so ticks may follow one another with no gap. The user must
// write gains through the cfg_ port while no tick is in flight; the block does
// not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module quad_attitude_pid_mixer_top #(
  parameter int ANGLE_WIDTH = qapm_pkg::ANGLE_WIDTH_DEF,
  parameter int SUM_WIDTH   = qapm_pkg::SUM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qapm_in_if.sink                           in_ch,
  qapm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [qapm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [qapm_pkg::GAIN_W-1:0]       cfg_wdata
);

  localparam int NS = qapm_pkg::NSTG;
  localparam int UW = qapm_pkg::u_width(ANGLE_WIDTH, SUM_WIDTH);

  logic [qapm_pkg::GAIN_W-1:0] kp_roll_r, kp_pitch_r, kp_yaw_r, kp_thrust_r;
  logic [qapm_pkg::GAIN_W-1:0] kd_roll_r, kd_pitch_r, kd_yaw_r, ki_axes_r;

  logic [NS-1:0] v_r, v_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          en_out;
  qapm_pkg::stage_ctl_t ctl;

  logic signed [UW-1:0] u_t, u_r, u_p, u_y;

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_roll_r   <= qapm_pkg::RST_KP_ROLL;
      kp_pitch_r  <= qapm_pkg::RST_KP_PITCH;
      kp_yaw_r    <= qapm_pkg::RST_KP_YAW;
      kp_thrust_r <= qapm_pkg::RST_KP_THRUST;
      kd_roll_r   <= qapm_pkg::RST_KD_ROLL;
      kd_pitch_r  <= qapm_pkg::RST_KD_PITCH;
      kd_yaw_r    <= qapm_pkg::RST_KD_YAW;
      ki_axes_r   <= qapm_pkg::RST_KI_AXES;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qapm_pkg::REG_KP_ROLL:   kp_roll_r   <= cfg_wdata;
        qapm_pkg::REG_KP_PITCH:  kp_pitch_r  <= cfg_wdata;
        qapm_pkg::REG_KP_YAW:    kp_yaw_r    <= cfg_wdata;
        qapm_pkg::REG_KP_THRUST: kp_thrust_r <= cfg_wdata;
        qapm_pkg::REG_KD_ROLL:   kd_roll_r   <= cfg_wdata;
        qapm_pkg::REG_KD_PITCH:  kd_pitch_r  <= cfg_wdata;
        qapm_pkg::REG_KD_YAW:    kd_yaw_r    <= cfg_wdata;
        qapm_pkg::REG_KI_AXES:   ki_axes_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // stage enables, bubbles collapse
  always_comb begin
    en_out        = !out_valid_r || out_ch.ready;
    ctl.en[NS-1]  = !v_r[NS-1] || en_out;
    for (int k = NS - 2; k >= 0; k--) begin
      ctl.en[k] = !v_r[k] || ctl.en[k+1];
    end
    ctl.upd = ctl.en[1] && v_r[0];

    v_nxt = v_r;
    if (ctl.en[0]) begin
      v_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (ctl.en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
    out_valid_nxt = en_out ? v_r[NS-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready  = ctl.en[0];
  assign out_ch.valid = out_valid_r;

  qapm_thrust_lane #(
    .AW (ANGLE_WIDTH),
    .SW (SUM_WIDTH)
  ) u_thrust (
    .clk  (clk),
    .ctl  (ctl),
    .want (in_ch.want_thrust),
    .kp   (kp_thrust_r),
    .t    (u_t)
  );

  qapm_axis_lane #(
    .AW (ANGLE_WIDTH),
    .SW (SUM_WIDTH)
  ) u_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .want  (in_ch.want_roll),
    .meas  (in_ch.meas_roll),
    .kp    (kp_roll_r),
    .kd    (kd_roll_r),
    .ki    (ki_axes_r),
    .u     (u_r)
  );

  qapm_axis_lane #(
    .AW (ANGLE_WIDTH),
    .SW (SUM_WIDTH)
  ) u_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .want  (in_ch.want_pitch),
    .meas  (in_ch.meas_pitch),
    .kp    (kp_pitch_r),
    .kd    (kd_pitch_r),
    .ki    (ki_axes_r),
    .u     (u_p)
  );

  qapm_axis_lane #(
    .AW (ANGLE_WIDTH),
    .SW (SUM_WIDTH)
  ) u_yaw (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .want  (in_ch.want_yaw),
    .meas  (in_ch.meas_yaw),
    .kp    (kp_yaw_r),
    .kd    (kd_yaw_r),
    .ki    (ki_axes_r),
    .u     (u_y)
  );

  qapm_mixer #(
    .UW (UW)
  ) u_mixer (
    .clk  (clk),
    .load (en_out),
    .t    (u_t),
    .r    (u_r),
    .p    (u_p),
    .y    (u_y),
    .m_fl (out_ch.motor_front_left),
    .m_bl (out_ch.motor_back_left),
    .m_br (out_ch.motor_back_right),
    .m_fr (out_ch.motor_front_right)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quad attitude PID controller and motor mixer.
// Control ticks go in through a bursty driver. Every motor command is checked
// against a fixed-point model of the three PID lanes, the thrust lane and the
// X mixer. Gains are reprogrammed between phases, with full-scale, zero and
// random settings. One phase runs the attitude lanes on the integral term
// alone, so the error sums build up and then wind back down.
// ----------------------------------------------------------------------------
module tb;

  localparam int AW            = qapm_pkg::ANGLE_WIDTH_DEF;
  localparam int GW            = qapm_pkg::GAIN_W;
  localparam int MW            = qapm_pkg::MOTOR_W;
  localparam int IW            = qapm_pkg::CFG_IDX_W;
  localparam int NUM_GAIN_REGS = 8;
  localparam int CFG_SLOTS     = 1 << IW;
  localparam int AX_ROLL       = 0;
  localparam int AX_PITCH      = 1;
  localparam int AX_YAW        = 2;
  localparam longint SUM_HI    = (longint'(1) <<< (qapm_pkg::SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_LO    = -SUM_HI - 1;
  localparam int SAT_TICKS     = 100;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_TICKS   = 100;
  localparam logic [GW-1:0] GAIN_FULL = '1;
  localparam logic [GW-1:0] GAIN_ONE  = 24'd65536;

  typedef struct {
    logic signed [AW-1:0] want_thrust;
    logic signed [AW-1:0] want_roll;
    logic signed [AW-1:0] want_pitch;
    logic signed [AW-1:0] want_yaw;
    logic signed [AW-1:0] meas_roll;
    logic signed [AW-1:0] meas_pitch;
    logic signed [AW-1:0] meas_yaw;
  } pid_tick_t;

  typedef struct {
    logic [MW-1:0] front_left;
    logic [MW-1:0] back_left;
    logic [MW-1:0] back_right;
    logic [MW-1:0] front_right;
  } motor_cmd_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_WAVE} rx_mode_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_idx;
  logic [GW-1:0] cfg_wdata;

  qapm_in_if #(.AW(AW)) in_ch ();
  qapm_out_if           out_ch ();

  quad_attitude_pid_mixer_top #(
    .ANGLE_WIDTH (AW),
    .SUM_WIDTH   (qapm_pkg::SUM_WIDTH_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pid_tick_t     tick_queue [$];
  motor_cmd_t    motors_due [$];
  logic [GW-1:0] gain [NUM_GAIN_REGS];
  longint        err_last [3] = '{0, 0, 0};
  longint        err_sum [3]  = '{0, 0, 0};
  int            fail_count   = 0;

  pid_tick_t cur_tick;
  int        burst_left;
  int        gap_left;
  rx_mode_t  rx_mode;
  int        mode_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor of gain * v / 2^16
  function automatic longint scale_q16(input logic [GW-1:0] g, input longint v);
    longint p;
    p = longint'(g) * v;
    return p >>> qapm_pkg::FRAC_W;
  endfunction

  function automatic longint pid_axis(input longint want, input longint meas,
                                      input logic [GW-1:0] kp,
                                      input logic [GW-1:0] kd, input int ax);
    longint e;
    longint s;
    longint u;
    e = want - meas;
    s = err_sum[ax] + e;
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    err_sum[ax] = s;
    u = scale_q16(kp, e) + scale_q16(kd, e - err_last[ax])
      + scale_q16(gain[qapm_pkg::REG_KI_AXES], s);
    err_last[ax] = e;
    return u;
  endfunction

  function automatic logic [MW-1:0] clamp_motor(input longint m);
    if (m < 0) return '0;
    if (m > longint'(qapm_pkg::MOTOR_MAX)) return qapm_pkg::MOTOR_MAX;
    return m[MW-1:0];
  endfunction

  function automatic motor_cmd_t predict_motors(input pid_tick_t tk);
    motor_cmd_t mc;
    longint     thr;
    longint     rl;
    longint     pt;
    longint     yw;
    thr = scale_q16(gain[qapm_pkg::REG_KP_THRUST], longint'(tk.want_thrust));
    rl  = pid_axis(tk.want_roll, tk.meas_roll, gain[qapm_pkg::REG_KP_ROLL],
                   gain[qapm_pkg::REG_KD_ROLL], AX_ROLL);
    pt  = pid_axis(tk.want_pitch, tk.meas_pitch, gain[qapm_pkg::REG_KP_PITCH],
                   gain[qapm_pkg::REG_KD_PITCH], AX_PITCH);
    yw  = pid_axis(tk.want_yaw, tk.meas_yaw, gain[qapm_pkg::REG_KP_YAW],
                   gain[qapm_pkg::REG_KD_YAW], AX_YAW);
    mc.front_left  = clamp_motor(thr - pt + rl + yw);
    mc.back_left   = clamp_motor(thr + pt + rl - yw);
    mc.back_right  = clamp_motor(thr + pt - rl + yw);
    mc.front_right = clamp_motor(thr - pt - rl - yw);
    return mc;
  endfunction

  function automatic void push_tick(input int th, input int r, input int p, input int y,
                                    input int mr, input int mp, input int my);
    pid_tick_t tk;
    tk.want_thrust = AW'(th);
    tk.want_roll   = AW'(r);
    tk.want_pitch  = AW'(p);
    tk.want_yaw    = AW'(y);
    tk.meas_roll   = AW'(mr);
    tk.meas_pitch  = AW'(mp);
    tk.meas_yaw    = AW'(my);
    tick_queue.push_back(tk);
  endfunction

  function automatic logic signed [AW-1:0] corner_val();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(AW-1){1'b0}}};
      1: return {1'b0, {(AW-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return AW'(1);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic pid_tick_t rand_tick();
    pid_tick_t tk;
    int        kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      // near hover: small errors, thrust request from 0 to 8191
      tk.want_thrust = AW'($urandom_range(0, 8191));
      tk.want_roll   = AW'(int'($urandom_range(0, 4095)) - 2048);
      tk.want_pitch  = AW'(int'($urandom_range(0, 4095)) - 2048);
      tk.want_yaw    = AW'(int'($urandom_range(0, 4095)) - 2048);
      tk.meas_roll   = AW'(int'(tk.want_roll) + int'($urandom_range(0, 511)) - 256);
      tk.meas_pitch  = AW'(int'(tk.want_pitch) + int'($urandom_range(0, 511)) - 256);
      tk.meas_yaw    = AW'(int'(tk.want_yaw) + int'($urandom_range(0, 511)) - 256);
    end else if (kind < 8) begin
      tk.want_thrust = AW'($urandom);
      tk.want_roll   = AW'($urandom);
      tk.want_pitch  = AW'($urandom);
      tk.want_yaw    = AW'($urandom);
      tk.meas_roll   = AW'($urandom);
      tk.meas_pitch  = AW'($urandom);
      tk.meas_yaw    = AW'($urandom);
    end else begin
      tk.want_thrust = corner_val();
      tk.want_roll   = corner_val();
      tk.want_pitch  = corner_val();
      tk.want_yaw    = corner_val();
      tk.meas_roll   = corner_val();
      tk.meas_pitch  = corner_val();
      tk.meas_yaw    = corner_val();
    end
    return tk;
  endfunction

  function automatic logic [GW-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return GAIN_FULL;
      2: return GW'($urandom_range(0, 131071));
      3: return GW'($urandom_range(0, 8191));
      default: return GW'($urandom);
    endcase
  endfunction

  task automatic write_gain(input logic [IW-1:0] idx, input logic [GW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx < NUM_GAIN_REGS) gain[idx] = val;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_gains(input logic [GW-1:0] val);
    for (int i = 0; i < NUM_GAIN_REGS; i++) write_gain(IW'(i), val);
    close_writes();
  endtask

  // sender idle and every motor command back
  task automatic wait_settled();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_ch.valid || motors_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [MW-1:0] exp_v,
                             input logic [MW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // request driver, bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) motors_due.push_back(predict_motors(cur_tick));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (tick_queue.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          cur_tick = tick_queue.pop_front();
          in_ch.want_thrust <= cur_tick.want_thrust;
          in_ch.want_roll   <= cur_tick.want_roll;
          in_ch.want_pitch  <= cur_tick.want_pitch;
          in_ch.want_yaw    <= cur_tick.want_yaw;
          in_ch.meas_roll   <= cur_tick.meas_roll;
          in_ch.meas_pitch  <= cur_tick.meas_pitch;
          in_ch.meas_yaw    <= cur_tick.meas_yaw;
          in_ch.valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // motor command monitor and receiver stall pattern
  always @(posedge clk) begin
    motor_cmd_t exp_cmd;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (motors_due.size() == 0) begin
          $error("motor command with no request outstanding");
          fail_count++;
        end else begin
          exp_cmd = motors_due.pop_front();
          check_field("motor_front_left", exp_cmd.front_left, out_ch.motor_front_left);
          check_field("motor_back_left", exp_cmd.back_left, out_ch.motor_back_left);
          check_field("motor_back_right", exp_cmd.back_right, out_ch.motor_back_right);
          check_field("motor_front_right", exp_cmd.front_right, out_ch.motor_front_right);
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= mode_left[3];
      endcase
    end
  end

  initial begin
    int n;
    in_ch.valid       = 1'b0;
    in_ch.want_thrust = '0;
    in_ch.want_roll   = '0;
    in_ch.want_pitch  = '0;
    in_ch.want_yaw    = '0;
    in_ch.meas_roll   = '0;
    in_ch.meas_pitch  = '0;
    in_ch.meas_yaw    = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    gain[qapm_pkg::REG_KP_ROLL]   = qapm_pkg::RST_KP_ROLL;
    gain[qapm_pkg::REG_KP_PITCH]  = qapm_pkg::RST_KP_PITCH;
    gain[qapm_pkg::REG_KP_YAW]    = qapm_pkg::RST_KP_YAW;
    gain[qapm_pkg::REG_KP_THRUST] = qapm_pkg::RST_KP_THRUST;
    gain[qapm_pkg::REG_KD_ROLL]   = qapm_pkg::RST_KD_ROLL;
    gain[qapm_pkg::REG_KD_PITCH]  = qapm_pkg::RST_KD_PITCH;
    gain[qapm_pkg::REG_KD_YAW]    = qapm_pkg::RST_KD_YAW;
    gain[qapm_pkg::REG_KI_AXES]   = qapm_pkg::RST_KI_AXES;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gains; first tick has no previous error
    push_tick(2048, 400, -300, 200, 0, 0, 0);
    push_tick(0, 0, 0, 0, 0, 0, 0);
    push_tick(32767, 0, 0, 0, 0, 0, 0);
    push_tick(-32768, 0, 0, 0, 0, 0, 0);
    push_tick(4096, 32767, 0, 0, -32768, 0, 0);
    push_tick(4096, -32768, 0, 0, 32767, 0, 0);
    push_tick(2048, 0, 32767, 0, 0, -32768, 0);
    push_tick(2048, 0, -32768, 0, 0, 32767, 0);
    push_tick(2048, 0, 0, 32767, 0, 0, -32768);
    push_tick(2048, 0, 0, -32768, 0, 0, 32767);
    push_tick(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    push_tick(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    push_tick(4096, -1, 0, 0, 0, 0, 0);
    push_tick(2048, 5, -7, 3, 9, 2, -4);
    repeat (4) tick_queue.push_back(rand_tick());
    wait_settled();

    // full-scale gains
    set_all_gains(GAIN_FULL);
    @(negedge clk);
    push_tick(1, 1, -1, 0, 0, 0, 0);
    repeat (8) tick_queue.push_back(rand_tick());
    wait_settled();

    // zero gains
    set_all_gains('0);
    @(negedge clk);
    repeat (8) tick_queue.push_back(rand_tick());
    wait_settled();

    // writes past the register map must leave the zero gains alone
    for (int i = NUM_GAIN_REGS; i < CFG_SLOTS; i++) write_gain(IW'(i), GW'($urandom));
    close_writes();
    @(negedge clk);
    push_tick(32767, 32767, -32768, 32767, -32768, 32767, -32768);
    repeat (8) tick_queue.push_back(rand_tick());
    wait_settled();

    // integral only: sums build up, then wind back toward zero
    write_gain(qapm_pkg::REG_KP_ROLL, '0);
    write_gain(qapm_pkg::REG_KP_PITCH, '0);
    write_gain(qapm_pkg::REG_KP_YAW, '0);
    write_gain(qapm_pkg::REG_KP_THRUST, GAIN_ONE);
    write_gain(qapm_pkg::REG_KD_ROLL, '0);
    write_gain(qapm_pkg::REG_KD_PITCH, '0);
    write_gain(qapm_pkg::REG_KD_YAW, '0);
    write_gain(qapm_pkg::REG_KI_AXES, 24'd1);
    close_writes();
    @(negedge clk);
    for (int i = 0; i < SAT_TICKS; i++) push_tick(2048, 32767, -32768, 0, -32768, 32767, 0);
    for (int i = 0; i < SAT_TICKS; i++) push_tick(2048, -32768, 32767, 0, 32767, -32768, 0);
    wait_settled();

    // random gain settings
    repeat (RAND_PHASES) begin
      for (int i = 0; i < NUM_GAIN_REGS; i++) write_gain(IW'(i), rand_gain());
      close_writes();
      @(negedge clk);
      repeat (PHASE_TICKS) tick_queue.push_back(rand_tick());
      wait_settled();
    end

    n = 0;
    while (n < 20) begin
      @(negedge clk);
      n++;
    end
    if (motors_due.size() != 0) begin
      $error("%0d motor commands never arrived", motors_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qapm_pkg.sv
rtl/qapm_if.sv
rtl/qapm_axis_lane.sv
rtl/qapm_thrust_lane.sv
rtl/qapm_mixer.sv
rtl/quad_attitude_pid_mixer_top.sv
tb/tb.sv
